/* rtl/prk_pkg.sv */
// ----------------------------------------------------------------------------
// prk_pkg: shared types and microcode for the pendulum RK4 stepper
// Holds sequencer states, operation and operand codes, the configuration
// register indexes and the microcode table that drives the datapath.
// ----------------------------------------------------------------------------
package prk_pkg;

  // pi in Q4.60, rounded down to the nearest representable value
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam int PC_W = 7;

  // configuration register indexes
  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_STEP    = 1'b1;

  // microcode entry points
  localparam logic [PC_W-1:0] PC_ADVANCE = 7'd0;
  localparam logic [PC_W-1:0] PC_LOAD    = 7'd44;
  localparam logic [PC_W-1:0] PC_ACCEL   = 7'd48;
  localparam logic [PC_W-1:0] PC_LIMIT   = 7'd75;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_MUL,
    OP_DIV,
    OP_WRAP,
    OP_ADD,
    OP_SUB,
    OP_HALF,
    OP_FOLD,
    OP_CLAMP,
    OP_SATW,
    OP_CALL,
    OP_RET,
    OP_DONE
  } op_e;

  // scratch entries first: their code is the scratch memory address
  typedef enum logic [3:0] {
    R_X,
    R_Q,
    R_T,
    R_P,
    R_KA,
    R_KW,
    R_SA,
    R_SW,
    R_TMP,
    R_A,
    R_W,
    R_H,
    R_G,
    R_ONE,
    R_ZERO
  } reg_e;

  typedef struct packed {
    op_e        op;
    reg_e       dst;
    reg_e       sa;
    reg_e       sb;
    logic [7:0] dv;
  } instr_t;

  function automatic instr_t mk(op_e op, reg_e dst, reg_e sa, reg_e sb, logic [7:0] dv);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.sa  = sa;
    i.sb  = sb;
    i.dv  = dv;
    return i;
  endfunction

  function automatic instr_t ucode(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // k1
      7'd0:  i = mk(OP_MUL,  R_KA,  R_H,    R_W,    8'd0);
      7'd1:  i = mk(OP_ADD,  R_SA,  R_KA,   R_ZERO, 8'd0);
      7'd2:  i = mk(OP_ADD,  R_X,   R_A,    R_ZERO, 8'd0);
      7'd3:  i = mk(OP_CALL, R_X,   R_ZERO, R_ZERO, 8'd0);
      7'd4:  i = mk(OP_MUL,  R_KW,  R_H,    R_P,    8'd0);
      7'd5:  i = mk(OP_ADD,  R_SW,  R_KW,   R_ZERO, 8'd0);
      // k2
      7'd6:  i = mk(OP_HALF, R_TMP, R_KW,   R_ZERO, 8'd0);
      7'd7:  i = mk(OP_ADD,  R_TMP, R_W,    R_TMP,  8'd0);
      7'd8:  i = mk(OP_MUL,  R_TMP, R_H,    R_TMP,  8'd0);
      7'd9:  i = mk(OP_HALF, R_X,   R_KA,   R_ZERO, 8'd0);
      7'd10: i = mk(OP_ADD,  R_X,   R_A,    R_X,    8'd0);
      7'd11: i = mk(OP_CALL, R_X,   R_ZERO, R_ZERO, 8'd0);
      7'd12: i = mk(OP_MUL,  R_KW,  R_H,    R_P,    8'd0);
      7'd13: i = mk(OP_ADD,  R_KA,  R_TMP,  R_ZERO, 8'd0);
      7'd14: i = mk(OP_ADD,  R_SA,  R_SA,   R_KA,   8'd0);
      7'd15: i = mk(OP_ADD,  R_SA,  R_SA,   R_KA,   8'd0);
      7'd16: i = mk(OP_ADD,  R_SW,  R_SW,   R_KW,   8'd0);
      7'd17: i = mk(OP_ADD,  R_SW,  R_SW,   R_KW,   8'd0);
      // k3
      7'd18: i = mk(OP_HALF, R_TMP, R_KW,   R_ZERO, 8'd0);
      7'd19: i = mk(OP_ADD,  R_TMP, R_W,    R_TMP,  8'd0);
      7'd20: i = mk(OP_MUL,  R_TMP, R_H,    R_TMP,  8'd0);
      7'd21: i = mk(OP_HALF, R_X,   R_KA,   R_ZERO, 8'd0);
      7'd22: i = mk(OP_ADD,  R_X,   R_A,    R_X,    8'd0);
      7'd23: i = mk(OP_CALL, R_X,   R_ZERO, R_ZERO, 8'd0);
      7'd24: i = mk(OP_MUL,  R_KW,  R_H,    R_P,    8'd0);
      7'd25: i = mk(OP_ADD,  R_KA,  R_TMP,  R_ZERO, 8'd0);
      7'd26: i = mk(OP_ADD,  R_SA,  R_SA,   R_KA,   8'd0);
      7'd27: i = mk(OP_ADD,  R_SA,  R_SA,   R_KA,   8'd0);
      7'd28: i = mk(OP_ADD,  R_SW,  R_SW,   R_KW,   8'd0);
      7'd29: i = mk(OP_ADD,  R_SW,  R_SW,   R_KW,   8'd0);
      // k4
      7'd30: i = mk(OP_ADD,  R_TMP, R_W,    R_KW,   8'd0);
      7'd31: i = mk(OP_MUL,  R_TMP, R_H,    R_TMP,  8'd0);
      7'd32: i = mk(OP_ADD,  R_X,   R_A,    R_KA,   8'd0);
      7'd33: i = mk(OP_CALL, R_X,   R_ZERO, R_ZERO, 8'd0);
      7'd34: i = mk(OP_MUL,  R_KW,  R_H,    R_P,    8'd0);
      7'd35: i = mk(OP_ADD,  R_SA,  R_SA,   R_TMP,  8'd0);
      7'd36: i = mk(OP_ADD,  R_SW,  R_SW,   R_KW,   8'd0);
      // state update
      7'd37: i = mk(OP_DIV,  R_SA,  R_SA,   R_ZERO, 8'd6);
      7'd38: i = mk(OP_ADD,  R_A,   R_A,    R_SA,   8'd0);
      7'd39: i = mk(OP_WRAP, R_A,   R_A,    R_ZERO, 8'd0);
      7'd40: i = mk(OP_DIV,  R_SW,  R_SW,   R_ZERO, 8'd6);
      7'd41: i = mk(OP_ADD,  R_W,   R_W,    R_SW,   8'd0);
      7'd42: i = mk(OP_SATW, R_W,   R_W,    R_ZERO, 8'd0);
      7'd43: i = mk(OP_DONE, R_X,   R_ZERO, R_ZERO, 8'd0);
      // load
      7'd44: i = mk(OP_WRAP, R_A,   R_A,    R_ZERO, 8'd0);
      7'd45: i = mk(OP_DONE, R_X,   R_ZERO, R_ZERO, 8'd0);
      // acceleration of angle X, result in P
      7'd48: i = mk(OP_WRAP, R_X,   R_X,    R_ZERO, 8'd0);
      7'd49: i = mk(OP_FOLD, R_X,   R_X,    R_ZERO, 8'd0);
      7'd50: i = mk(OP_MUL,  R_Q,   R_X,    R_X,    8'd0);
      7'd51: i = mk(OP_ADD,  R_T,   R_ONE,  R_ZERO, 8'd0);
      7'd52: i = mk(OP_MUL,  R_P,   R_Q,    R_T,    8'd0);
      7'd53: i = mk(OP_DIV,  R_P,   R_P,    R_ZERO, 8'd156);
      7'd54: i = mk(OP_SUB,  R_T,   R_ONE,  R_P,    8'd0);
      7'd55: i = mk(OP_MUL,  R_P,   R_Q,    R_T,    8'd0);
      7'd56: i = mk(OP_DIV,  R_P,   R_P,    R_ZERO, 8'd110);
      7'd57: i = mk(OP_SUB,  R_T,   R_ONE,  R_P,    8'd0);
      7'd58: i = mk(OP_MUL,  R_P,   R_Q,    R_T,    8'd0);
      7'd59: i = mk(OP_DIV,  R_P,   R_P,    R_ZERO, 8'd72);
      7'd60: i = mk(OP_SUB,  R_T,   R_ONE,  R_P,    8'd0);
      7'd61: i = mk(OP_MUL,  R_P,   R_Q,    R_T,    8'd0);
      7'd62: i = mk(OP_DIV,  R_P,   R_P,    R_ZERO, 8'd42);
      7'd63: i = mk(OP_SUB,  R_T,   R_ONE,  R_P,    8'd0);
      7'd64: i = mk(OP_MUL,  R_P,   R_Q,    R_T,    8'd0);
      7'd65: i = mk(OP_DIV,  R_P,   R_P,    R_ZERO, 8'd20);
      7'd66: i = mk(OP_SUB,  R_T,   R_ONE,  R_P,    8'd0);
      7'd67: i = mk(OP_MUL,  R_P,   R_Q,    R_T,    8'd0);
      7'd68: i = mk(OP_DIV,  R_P,   R_P,    R_ZERO, 8'd6);
      7'd69: i = mk(OP_SUB,  R_T,   R_ONE,  R_P,    8'd0);
      7'd70: i = mk(OP_MUL,  R_P,   R_X,    R_T,    8'd0);
      7'd71: i = mk(OP_CLAMP, R_P,  R_P,    R_ZERO, 8'd0);
      7'd72: i = mk(OP_MUL,  R_P,   R_G,    R_P,    8'd0);
      7'd73: i = mk(OP_SUB,  R_P,   R_ZERO, R_P,    8'd0);
      7'd74: i = mk(OP_RET,  R_X,   R_ZERO, R_ZERO, 8'd0);
      default: i = mk(OP_DONE, R_X, R_ZERO, R_ZERO, 8'd0);
    endcase
    return i;
  endfunction

endpackage

/* rtl/pendulum_rk4_step_top.sv */
// ----------------------------------------------------------------------------
// pendulum_rk4_step_top: simple pendulum, one RK4 step per transfer
// Microcoded sequencer over a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// Each input transfer either loads angle and rate (tuser = 1) or advances the
// pendulum by one classical fourth-order Runge-Kutta step of size h
// (tuser = 0); each produces exactly one output transfer with the new angle,
// the new rate and a flag set when the rate clamped to 32 bits. Values are
// signed fixed point with FRACTION_BITS fraction bits; the angle is wrapped
// to [-pi, pi). Sine uses a folded Taylor series of seven terms. The block
// works on one item at a time: every multiply and every division (by a
// series constant, by six, or by two pi for wrapping) runs through a serial
// multiplier or divider that handles one bit per cycle over
// W = FRACTION_BITS + 20 bits. An advance runs 75 serial multiplies and
// divisions for the four slope evaluations and the final update; a load
// runs one division, to wrap the angle. A new item is taken once the
// previous result sits in the output register, even if that result has not
// yet been taken. Write configuration only while idle.
module pendulum_rk4_step_top #(
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [26:0] load_angle, [58:27] load_rate
  input  logic        s_axis_tuser,  // [0] opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [26:0] angle, [58:27] rate
  output logic        m_axis_tuser   // [0] rate_saturated
);

  localparam int W  = FRACTION_BITS + 20;
  localparam int DW = FRACTION_BITS + 3;

  localparam logic [63:0] PI_RAW =
      ((prk_pkg::PI_Q60 >> (59 - FRACTION_BITS)) + 64'd1) >> 1;
  localparam logic [63:0] TWO_PI_RAW = PI_RAW << 1;
  localparam logic signed [W-1:0] PI      = PI_RAW[W-1:0];
  localparam logic signed [W-1:0] HALF_PI = PI >>> 1;
  localparam logic [DW-1:0]       TWO_PI  = TWO_PI_RAW[DW-1:0];
  localparam logic signed [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic signed [W-1:0] RATE_MAX = {{(W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [W-1:0] RATE_MIN = {{(W-31){1'b1}}, {31{1'b0}}};

  // configuration
  logic signed [31:0] g_q;
  logic [24:0]        step_q;

  // sequencer
  prk_pkg::state_e state_q, state_d;
  logic [prk_pkg::PC_W-1:0] pc_q, pc_d, ret_q, ret_d;
  prk_pkg::instr_t ins;

  // architectural state and scratch
  logic signed [W-1:0] a_q, w_q;
  logic signed [W-1:0] mem_q [16];
  logic signed [W-1:0] rda_q, rdb_q;
  logic                sat_q, sat_d;
  logic                neg_q, neg_d;

  // output register
  logic        m_valid_q;
  logic [26:0] out_angle_q;
  logic [31:0] out_rate_q;
  logic        out_sat_q;
  logic        out_load;

  // datapath
  logic signed [W-1:0] opa, opb, g_val, h_val, u_val, res;
  logic [W-1:0]        step_ext, rem_ext;
  logic                wr_en;
  logic                accept;
  logic                mul_start, mul_done, div_start, div_done;
  logic signed [W-1:0] mul_res;
  logic [W-1:0]        div_num, div_quo;
  logic [DW-1:0]       div_den, div_rem;

  assign ins      = prk_pkg::ucode(pc_q);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == prk_pkg::ST_IDLE);

  assign g_val    = {{(W-32){g_q[31]}}, g_q};
  assign step_ext = {{(W-25){1'b0}}, step_q};
  // clamp h to one second
  assign h_val    = (step_ext > $unsigned(ONE)) ? ONE : $signed(step_ext);

  // operand select: scratch reads come from the registered memory ports
  always_comb begin
    case (ins.sa)
      prk_pkg::R_A:    opa = a_q;
      prk_pkg::R_W:    opa = w_q;
      prk_pkg::R_H:    opa = h_val;
      prk_pkg::R_G:    opa = g_val;
      prk_pkg::R_ONE:  opa = ONE;
      prk_pkg::R_ZERO: opa = '0;
      default:         opa = rda_q;
    endcase
    case (ins.sb)
      prk_pkg::R_A:    opb = a_q;
      prk_pkg::R_W:    opb = w_q;
      prk_pkg::R_H:    opb = h_val;
      prk_pkg::R_G:    opb = g_val;
      prk_pkg::R_ONE:  opb = ONE;
      prk_pkg::R_ZERO: opb = '0;
      default:         opb = rdb_q;
    endcase
  end

  assign u_val   = opa + PI;
  assign div_den = (ins.op == prk_pkg::OP_WRAP) ? TWO_PI : {{(DW-8){1'b0}}, ins.dv};
  assign div_num = (ins.op == prk_pkg::OP_WRAP)
                 ? (u_val[W-1] ? W'(-u_val) : W'(u_val))
                 : (opa[W-1] ? W'(-opa) : W'(opa));

  prk_mul #(.W(W), .FB(FRACTION_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  prk_div #(.W(W), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // non-negative remainder, shifted back to [-pi, pi)
  always_comb begin
    rem_ext = {{(W-DW){1'b0}}, div_rem};
    if (neg_q && (div_rem != '0)) begin
      rem_ext = {{(W-DW){1'b0}}, TWO_PI} - rem_ext;
    end
  end

  // next state, writes and unit starts
  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    ret_d     = ret_q;
    sat_d     = sat_q;
    neg_d     = neg_q;
    wr_en     = 1'b0;
    res       = opa;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      prk_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = prk_pkg::ST_READ;
          pc_d    = s_axis_tuser ? prk_pkg::PC_LOAD : prk_pkg::PC_ADVANCE;
          if (s_axis_tuser) begin
            sat_d = 1'b0;
          end
        end
      end
      prk_pkg::ST_READ: begin
        state_d = prk_pkg::ST_EXEC;
      end
      prk_pkg::ST_EXEC: begin
        state_d = prk_pkg::ST_READ;
        pc_d    = pc_q + 1'b1;
        case (ins.op)
          prk_pkg::OP_ADD: begin
            res   = opa + opb;
            wr_en = 1'b1;
          end
          prk_pkg::OP_SUB: begin
            res   = opa - opb;
            wr_en = 1'b1;
          end
          prk_pkg::OP_HALF: begin
            // halve, truncating toward zero
            res   = (opa + $signed({{(W-1){1'b0}}, opa[W-1]})) >>> 1;
            wr_en = 1'b1;
          end
          prk_pkg::OP_FOLD: begin
            if (opa > HALF_PI) begin
              res = PI - opa;
            end else if (opa < -HALF_PI) begin
              res = -PI - opa;
            end
            wr_en = 1'b1;
          end
          prk_pkg::OP_CLAMP: begin
            if (opa > ONE) begin
              res = ONE;
            end else if (opa < -ONE) begin
              res = -ONE;
            end
            wr_en = 1'b1;
          end
          prk_pkg::OP_SATW: begin
            sat_d = 1'b0;
            if (opa > RATE_MAX) begin
              res   = RATE_MAX;
              sat_d = 1'b1;
            end else if (opa < RATE_MIN) begin
              res   = RATE_MIN;
              sat_d = 1'b1;
            end
            wr_en = 1'b1;
          end
          prk_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_d   = prk_pkg::ST_WAIT;
            pc_d      = pc_q;
          end
          prk_pkg::OP_DIV: begin
            div_start = 1'b1;
            neg_d     = opa[W-1];
            state_d   = prk_pkg::ST_WAIT;
            pc_d      = pc_q;
          end
          prk_pkg::OP_WRAP: begin
            div_start = 1'b1;
            neg_d     = u_val[W-1];
            state_d   = prk_pkg::ST_WAIT;
            pc_d      = pc_q;
          end
          prk_pkg::OP_CALL: begin
            ret_d = pc_q + 1'b1;
            pc_d  = prk_pkg::PC_ACCEL;
          end
          prk_pkg::OP_RET: begin
            pc_d = ret_q;
          end
          prk_pkg::OP_DONE: begin
            state_d = prk_pkg::ST_OUT;
            pc_d    = pc_q;
          end
          default: begin
            state_d = prk_pkg::ST_OUT;
            pc_d    = pc_q;
          end
        endcase
      end
      prk_pkg::ST_WAIT: begin
        if (mul_done) begin
          res     = mul_res;
          wr_en   = 1'b1;
          pc_d    = pc_q + 1'b1;
          state_d = prk_pkg::ST_READ;
        end else if (div_done) begin
          if (ins.op == prk_pkg::OP_WRAP) begin
            res = $signed(rem_ext) - PI;
          end else begin
            res = neg_q ? -$signed(div_quo) : $signed(div_quo);
          end
          wr_en   = 1'b1;
          pc_d    = pc_q + 1'b1;
          state_d = prk_pkg::ST_READ;
        end
      end
      prk_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = prk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= prk_pkg::ST_IDLE;
      pc_q      <= '0;
      ret_q     <= '0;
      sat_q     <= 1'b0;
      neg_q     <= 1'b0;
      m_valid_q <= 1'b0;
      a_q       <= '0;
      w_q       <= '0;
      g_q       <= 32'sd164584489;
      step_q    <= 25'd167772;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ret_q   <= ret_d;
      sat_q   <= sat_d;
      neg_q   <= neg_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (accept && s_axis_tuser) begin
        a_q <= {{(W-27){s_axis_tdata[26]}}, s_axis_tdata[26:0]};
        w_q <= {{(W-32){s_axis_tdata[58]}}, s_axis_tdata[58:27]};
      end else if (wr_en && (ins.dst == prk_pkg::R_A)) begin
        a_q <= res;
      end else if (wr_en && (ins.dst == prk_pkg::R_W)) begin
        w_q <= res;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          prk_pkg::CFG_GRAVITY: g_q    <= cfg_data_i;
          prk_pkg::CFG_STEP:    step_q <= cfg_data_i[24:0];
          default: ;
        endcase
      end
    end
  end

  // scratch memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en && (ins.dst != prk_pkg::R_A) && (ins.dst != prk_pkg::R_W)) begin
      mem_q[4'(ins.dst)] <= res;
    end
    rda_q <= mem_q[4'(ins.sa)];
    rdb_q <= mem_q[4'(ins.sb)];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_angle_q <= a_q[26:0];
      out_rate_q  <= w_q[31:0];
      out_sat_q   <= sat_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, out_rate_q, out_angle_q};
  assign m_axis_tuser  = out_sat_q;

`ifndef NO_ASSERTIONS
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != prk_pkg::ST_IDLE) |-> (pc_q < prk_pkg::PC_LIMIT))
    else $error("microcode address out of range");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == prk_pkg::ST_READ))
    else $error("accepted transfer did not start the sequencer");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_sat_q) |->
      (out_rate_q == 32'h7FFF_FFFF || out_rate_q == 32'h8000_0000))
    else $error("saturation flag without a clamped rate");
`endif

endmodule

/* rtl/prk_mul.sv */
// ----------------------------------------------------------------------------
// prk_mul: bit-serial fixed-point multiplier
// Sign-magnitude shift-add, one multiplier bit per cycle; the product is
// shifted right by the fraction width with the magnitude truncated.
// ----------------------------------------------------------------------------
module prk_mul #(
  parameter int W  = 44,
  parameter int FB = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] res_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [W-1:0]  a_q, hi_q, lo_q;
  logic [W-1:0]  a_mag, b_mag;
  logic [W:0]    sum;
  logic [2*W-1:0] prod;
  logic [W-1:0]  mag;

  assign a_mag = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign b_mag = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
  assign prod  = {hi_q, lo_q};
  assign mag   = prod[FB+W-1:FB];
  assign res_o = neg_q ? -$signed(mag) : $signed(mag);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the partial product right, one multiplier bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_mag;
      lo_q  <= b_mag;
      hi_q  <= '0;
      neg_q <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      hi_q <= sum[W:1];
      lo_q <= {sum[0], lo_q[W-1:1]};
    end
  end

endmodule

/* rtl/prk_div.sv */
// ----------------------------------------------------------------------------
// prk_div: bit-serial restoring divider
// Unsigned dividend, one quotient bit per cycle, narrow remainder path.
// ----------------------------------------------------------------------------
module prk_div #(
  parameter int W  = 44,
  parameter int DW = 27
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [W-1:0]  quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  num_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial  = {rem_q, num_q[W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule
